### rtl/cvt_pkg.sv
// ----------------------------------------------------------------------------
// cvt_pkg
// Shared types and codes for the current value table tracker.
// ----------------------------------------------------------------------------
package cvt_pkg;

  // default table geometry
  localparam int CVT_NUM_SOURCES = 64;
  localparam int CVT_NUM_TYPES   = 64;

  // register reset values
  localparam logic [31:0] EXPIRY_RESET = 32'd1000000;
  localparam logic [15:0] WINDOW_RESET = 16'd32767;

  // configuration register indexes
  localparam logic REG_EXPIRY = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_GET   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_STATS = 3'd4,
    OP_SET   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SOURCE  = 3'd1,
    ST_BAD_TYPE    = 3'd2,
    ST_NO_ENTRY    = 3'd3,
    ST_BAD_LENGTH  = 3'd4,
    ST_DUPLICATE   = 3'd5,
    ST_ORDER       = 3'd6,
    ST_NOT_UPDATED = 3'd7
  } status_t;

  // sticky event bits
  localparam logic [7:0] EV_BAD_SOURCE = 8'h01;
  localparam logic [7:0] EV_BAD_TYPE   = 8'h02;
  localparam logic [7:0] EV_NO_ENTRY   = 8'h04;
  localparam logic [7:0] EV_BAD_LENGTH = 8'h08;
  localparam logic [7:0] EV_DUPLICATE  = 8'h10;
  localparam logic [7:0] EV_ORDER      = 8'h20;
  localparam logic [7:0] EV_EXPIRED    = 8'h40;
  localparam logic [7:0] EV_JUMPED     = 8'h80;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic        present;
    logic [15:0] length;
    logic [15:0] seq;
    logic [63:0] stamp;
    logic        updated;
  } entry_t;

endpackage

### rtl/current_value_table_tracker_unit.sv
// ----------------------------------------------------------------------------
// current_value_table_tracker_unit
// Per (source, type) table of packet metadata with duplicate, order and
// expiry screening, plus event counters.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at a clock edge with start high and busy
//   low. busy is high from that edge until the result is built, so one
//   command is in flight at a time.
//   Result channel: done is high for exactly one cycle with status and the
//   other result fields; the receiver cannot stall it. Fields an operation
//   does not produce read as zero.
//   Sequence: the entry is read into a register at the accepting edge, then
//   checked and written back in the exec state, and done and the result are
//   registered at the edge that ends it. A new command can be taken at the
//   edge that ends the done cycle, so commands do not overlap; the pace is
//   set by the registered read of the entry memory.
//   Configuration: cfg_we writes cfg_data to register cfg_addr (0 expiry
//   time, 1 accept window) at once; write only while idle.
//   Reset: rst (synchronous) clears counters and registers, then a clearing
//   pass writes the NUM_SOURCES * NUM_TYPES table entries (4096 by default)
//   to zero, one per cycle, with busy high.
// ----------------------------------------------------------------------------
module current_value_table_tracker_unit #(
  parameter int NUM_SOURCES = cvt_pkg::CVT_NUM_SOURCES,
  parameter int NUM_TYPES   = cvt_pkg::CVT_NUM_TYPES
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [31:0]        cfg_data,
  // command
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic [7:0]         source,
  input  logic [7:0]         msg_type,
  input  logic [15:0]        sequence_req,
  input  logic signed [63:0] stamp_us,
  input  logic [15:0]        length,
  input  logic               present,
  // result
  output logic               done,
  output logic [2:0]         status,
  output logic               expired,
  output logic               jumped,
  output logic [15:0]        seq_out,
  output logic signed [63:0] stamp_out,
  output logic [15:0]        unique_count,
  output logic [15:0]        unread_count,
  output logic [15:0]        invalid_count,
  output logic [7:0]         sticky_events
);
  import cvt_pkg::*;

  localparam int TABLE_SIZE = NUM_SOURCES * NUM_TYPES;
  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  // configuration registers
  logic [31:0] expiry_time;
  logic [15:0] accept_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_time   <= EXPIRY_RESET;
      accept_window <= WINDOW_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == REG_EXPIRY) expiry_time <= cfg_data;
      else                        accept_window <= cfg_data[15:0];
    end
  end

  // entry memory
  entry_t          mem [TABLE_SIZE];
  entry_t          mem_rdata;
  entry_t          mem_wdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[rd_addr];
  end

  // slot address and range checks on the incoming word
  logic [16:0] slot_wide;
  logic        src_in_range;
  logic        typ_in_range;

  assign slot_wide    = 17'(source) * 17'(NUM_TYPES) + 17'(msg_type);
  assign rd_addr      = slot_wide[AW-1:0];
  assign src_in_range = ({1'b0, source} < 9'(NUM_SOURCES));
  assign typ_in_range = ({1'b0, msg_type} < 9'(NUM_TYPES));

  // command capture
  state_t        state, state_next;
  logic          accept;
  logic [2:0]    op_q;
  logic          src_ok_q;
  logic          typ_ok_q;
  logic [AW-1:0] slot_q;
  logic [15:0]   seq_q;
  logic [63:0]   stamp_q;
  logic [15:0]   len_q;
  logic          pres_q;
  logic [AW-1:0] clr_addr;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= operation;
      src_ok_q <= src_in_range;
      typ_ok_q <= typ_in_range;
      slot_q   <= rd_addr;
      seq_q    <= sequence_req;
      stamp_q  <= stamp_us;
      len_q    <= length;
      pres_q   <= present;
    end
  end

  // counters
  logic [31:0] unique_total, unique_total_next;
  logic [31:0] unread_total, unread_total_next;
  logic [31:0] invalid_total, invalid_total_next;
  logic [7:0]  event_mask, event_mask_next;

  // result next values
  logic        done_next;
  logic [2:0]  status_next;
  logic        expired_next;
  logic        jumped_next;
  logic [15:0] seq_out_next;
  logic [63:0] stamp_out_next;
  logic [15:0] unique_count_next;
  logic [15:0] unread_count_next;
  logic [15:0] invalid_count_next;
  logic [7:0]  sticky_next;

  // put checks
  logic [63:0] age;
  logic        recent;
  logic [15:0] seq_step;
  logic [15:0] seq_plus1;
  logic        range_ok;

  assign age       = stamp_q - mem_rdata.stamp;
  assign recent    = age[63] || (age < {32'd0, expiry_time});
  assign seq_step  = seq_q - mem_rdata.seq;
  assign seq_plus1 = mem_rdata.seq + 16'd1;
  assign range_ok  = src_ok_q && typ_ok_q;

  // next state, table update and result
  always_comb begin
    state_next         = state;
    mem_we             = 1'b0;
    mem_waddr          = slot_q;
    mem_wdata          = mem_rdata;
    unique_total_next  = unique_total;
    unread_total_next  = unread_total;
    invalid_total_next = invalid_total;
    event_mask_next    = event_mask;
    done_next          = 1'b0;
    status_next        = ST_OK;
    expired_next       = 1'b0;
    jumped_next        = 1'b0;
    seq_out_next       = '0;
    stamp_out_next     = '0;
    unique_count_next  = '0;
    unread_count_next  = '0;
    invalid_count_next = '0;
    sticky_next        = '0;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AW'(TABLE_SIZE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        if (!src_ok_q)      status_next = ST_BAD_SOURCE;
        else if (!typ_ok_q) status_next = ST_BAD_TYPE;
        case (op_q)
          OP_PUT: begin
            if (range_ok && !mem_rdata.present)            status_next = ST_NO_ENTRY;
            else if (range_ok && len_q != mem_rdata.length) status_next = ST_BAD_LENGTH;
            if (status_next != ST_OK) begin
              invalid_total_next = invalid_total + 32'd1;
              case (status_next)
                ST_BAD_SOURCE: event_mask_next = event_mask | EV_BAD_SOURCE;
                ST_BAD_TYPE:   event_mask_next = event_mask | EV_BAD_TYPE;
                ST_NO_ENTRY:   event_mask_next = event_mask | EV_NO_ENTRY;
                default:       event_mask_next = event_mask | EV_BAD_LENGTH;
              endcase
            end else if (recent && seq_q == mem_rdata.seq) begin
              status_next     = ST_DUPLICATE;
              event_mask_next = event_mask | EV_DUPLICATE;
            end else if (recent && seq_step > accept_window) begin
              status_next     = ST_ORDER;
              event_mask_next = event_mask | EV_ORDER;
            end else begin
              // accepted put
              expired_next       = !recent;
              jumped_next        = (seq_plus1 != seq_q);
              event_mask_next    = event_mask
                                   | (recent ? 8'h00 : EV_EXPIRED)
                                   | ((seq_plus1 != seq_q) ? EV_JUMPED : 8'h00);
              unique_total_next  = unique_total + 32'd1;
              if (mem_rdata.updated) unread_total_next = unread_total + 32'd1;
              mem_we             = 1'b1;
              mem_wdata.seq      = seq_q;
              mem_wdata.stamp    = stamp_q;
              mem_wdata.updated  = 1'b1;
            end
          end
          OP_GET, OP_PEEK: begin
            if (range_ok) begin
              if (!mem_rdata.present) begin
                status_next = ST_NO_ENTRY;
              end else if (op_q == OP_GET && !mem_rdata.updated) begin
                status_next = ST_NOT_UPDATED;
              end else begin
                seq_out_next   = mem_rdata.seq;
                stamp_out_next = mem_rdata.stamp;
                if (op_q == OP_GET) begin
                  mem_we            = 1'b1;
                  mem_wdata.updated = 1'b0;
                end
              end
            end
          end
          OP_CLEAR: begin
            if (range_ok) begin
              if (!mem_rdata.present) begin
                status_next = ST_NO_ENTRY;
              end else begin
                mem_we             = 1'b1;
                mem_wdata.seq      = '0;
                mem_wdata.stamp    = '0;
                mem_wdata.updated  = 1'b0;
              end
            end
          end
          OP_STATS: begin
            status_next        = ST_OK;
            unique_count_next  = unique_total[15:0];
            unread_count_next  = unread_total[15:0];
            invalid_count_next = invalid_total[15:0];
            sticky_next        = event_mask;
            unique_total_next  = '0;
            unread_total_next  = '0;
            invalid_total_next = '0;
            event_mask_next    = '0;
          end
          OP_SET: begin
            if (range_ok) begin
              mem_we    = 1'b1;
              mem_wdata = '0;
              mem_wdata.present = pres_q;
              mem_wdata.length  = pres_q ? len_q : 16'd0;
            end
          end
          default: begin
            status_next = ST_OK;
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, sweep counter and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      unique_total  <= '0;
      unread_total  <= '0;
      invalid_total <= '0;
      event_mask    <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      unique_total  <= unique_total_next;
      unread_total  <= unread_total_next;
      invalid_total <= invalid_total_next;
      event_mask    <= event_mask_next;
      done          <= done_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    status        <= status_next;
    expired       <= expired_next;
    jumped        <= jumped_next;
    seq_out       <= seq_out_next;
    stamp_out     <= stamp_out_next;
    unique_count  <= unique_count_next;
    unread_count  <= unread_count_next;
    invalid_count <= invalid_count_next;
    sticky_events <= sticky_next;
  end

endmodule
